// ===== hw/rtl/npcm_pkg.sv =====
package npcm_pkg;

  localparam int PaletteDepth = 64;
  localparam int IdxW         = $clog2(PaletteDepth);
  localparam int CntW         = IdxW + 1;
  localparam int ChanW        = 8;
  localparam int SqW          = 2 * ChanW;
  localparam int DistW        = SqW + 2;
  localparam int CfgIdxW      = 2;

  // The compare tree reduces four nodes per stage over three stages.
  localparam int Tree1N = PaletteDepth / 4;
  localparam int Tree2N = Tree1N / 4;

  typedef enum logic {
    OpWrite = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef enum logic {
    TblBlock = 1'b0,
    TblPure  = 1'b1
  } table_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPureMode   = 2'd0,
    RegPureCount  = 2'd1,
    RegBlockCount = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } diff_t;

  typedef struct packed {
    logic [SqW-1:0] red;
    logic [SqW-1:0] green;
    logic [SqW-1:0] blue;
  } sq_t;

  typedef struct packed {
    logic             vld;
    logic [DistW-1:0] distance;
    logic [IdxW-1:0]  idx;
  } node_t;

  function automatic logic [ChanW-1:0] abs_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
    logic [ChanW-1:0] res;
    res = (a >= b) ? (a - b) : (b - a);
    return res;
  endfunction

  // The first argument must carry the lower index, so that ties keep it.
  function automatic node_t pick2(node_t a, node_t b);
    node_t res;
    res = (a.vld && (!b.vld || (a.distance <= b.distance))) ? a : b;
    return res;
  endfunction

  function automatic node_t pick4(node_t n0, node_t n1, node_t n2, node_t n3);
    node_t lo;
    node_t hi;
    lo = pick2(n0, n1);
    hi = pick2(n2, n3);
    return pick2(lo, hi);
  endfunction

endpackage

// ===== hw/rtl/npcm_dist.sv =====
module npcm_dist import npcm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  rgb_t                    color_i,
  input  rgb_t [PaletteDepth-1:0] entries_i,
  input  logic [PaletteDepth-1:0] mask_i,
  input  logic                    sel_pure_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output node_t [PaletteDepth-1:0] nodes_o,
  output logic                    sel_pure_o
);

  logic                    v1_q, v2_q, v3_q;
  logic                    en1, en2, en3;
  diff_t [PaletteDepth-1:0] diff_d, diff_q;
  sq_t   [PaletteDepth-1:0] sq_d, sq_q;
  node_t [PaletteDepth-1:0] node_d, node_q;
  logic [PaletteDepth-1:0] mask1_q, mask2_q;
  logic                    pure1_q, pure2_q, pure3_q;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  for (genvar i = 0; i < PaletteDepth; i++) begin : g_lane
    always_comb begin
      diff_d[i].red   = abs_diff(entries_i[i].red, color_i.red);
      diff_d[i].green = abs_diff(entries_i[i].green, color_i.green);
      diff_d[i].blue  = abs_diff(entries_i[i].blue, color_i.blue);
    end

    always_comb begin
      sq_d[i].red   = SqW'(diff_q[i].red) * SqW'(diff_q[i].red);
      sq_d[i].green = SqW'(diff_q[i].green) * SqW'(diff_q[i].green);
      sq_d[i].blue  = SqW'(diff_q[i].blue) * SqW'(diff_q[i].blue);
    end

    always_comb begin
      node_d[i].vld      = mask2_q[i];
      node_d[i].distance = DistW'(sq_q[i].red) + DistW'(sq_q[i].green) +
                           DistW'(sq_q[i].blue);
      node_d[i].idx      = IdxW'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      diff_q  <= diff_d;
      mask1_q <= mask_i;
      pure1_q <= sel_pure_i;
    end
    if (en2) begin
      sq_q    <= sq_d;
      mask2_q <= mask1_q;
      pure2_q <= pure1_q;
    end
    if (en3) begin
      node_q  <= node_d;
      pure3_q <= pure2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign nodes_o     = node_q;
  assign sel_pure_o  = pure3_q;

endmodule

// ===== hw/rtl/npcm_min_tree.sv =====
module npcm_min_tree import npcm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  node_t [PaletteDepth-1:0] nodes_i,
  input  logic                     sel_pure_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output node_t                    best_o,
  output logic                     sel_pure_o
);

  logic                  v1_q, v2_q, v3_q;
  logic                  en1, en2, en3;
  node_t [Tree1N-1:0]    t1_d, t1_q;
  node_t [Tree2N-1:0]    t2_d, t2_q;
  node_t                 t3_pick, t3_d, t3_q;
  logic                  pure1_q, pure2_q, pure3_q;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  for (genvar j = 0; j < Tree1N; j++) begin : g_t1
    assign t1_d[j] = pick4(nodes_i[4*j], nodes_i[4*j+1], nodes_i[4*j+2], nodes_i[4*j+3]);
  end

  for (genvar j = 0; j < Tree2N; j++) begin : g_t2
    assign t2_d[j] = pick4(t1_q[4*j], t1_q[4*j+1], t1_q[4*j+2], t1_q[4*j+3]);
  end

  // An empty table reports index and distance as zero.
  always_comb begin
    t3_pick = pick4(t2_q[0], t2_q[1], t2_q[2], t2_q[3]);
    t3_d    = t3_pick;
    if (!t3_pick.vld) begin
      t3_d.distance = '0;
      t3_d.idx      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      t1_q    <= t1_d;
      pure1_q <= sel_pure_i;
    end
    if (en2) begin
      t2_q    <= t2_d;
      pure2_q <= pure1_q;
    end
    if (en3) begin
      t3_q    <= t3_d;
      pure3_q <= pure2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign best_o      = t3_q;
  assign sel_pure_o  = pure3_q;

endmodule

// ===== hw/rtl/nearest_palette_color_match.sv =====
// Nearest palette color match. Two palettes of 64 RGB entries (pure and block) are loaded
// by write items, which take effect at the edge that accepts them and return nothing. A
// query item returns the first index of least squared RGB distance in the chosen palette.
// One query is accepted per cycle unless a stalled output backs up the pipeline, and its
// result is presented once it has passed the registered stages: three stages of 64
// parallel distance lanes (difference, square, sum) feed a three-stage four-way compare
// tree. A stalled output holds its result while bubbles in the pipeline still fill, and
// configuration writes are always accepted.
module nearest_palette_color_match import npcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic                table_select_i,
  input  logic [IdxW-1:0]     entry_index_i,
  input  logic [ChanW-1:0]    red_i,
  input  logic [ChanW-1:0]    green_i,
  input  logic [ChanW-1:0]    blue_i,
  input  logic                pure_request_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic                used_pure_table_o,
  output logic [IdxW-1:0]     best_index_o,
  output logic [DistW-1:0]    best_distance_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CntW-1:0]     cfg_data_i
);

  logic                     pure_mode_q;
  logic [CntW-1:0]          pure_count_q;
  logic [CntW-1:0]          block_count_q;
  rgb_t [PaletteDepth-1:0]  pure_table_q;
  rgb_t [PaletteDepth-1:0]  block_table_q;
  rgb_t [PaletteDepth-1:0]  sel_entries;
  logic [PaletteDepth-1:0]  lane_mask;
  rgb_t                     color;
  logic                     sel_pure;
  logic [CntW-1:0]          sel_count;
  logic                     accept;
  logic                     wr_en;
  logic                     query_valid;
  logic                     cfg_en;
  logic                     dist_ready;
  logic                     dist_valid;
  logic                     dist_pure;
  node_t [PaletteDepth-1:0] dist_nodes;
  logic                     tree_ready;
  node_t                    best;
  logic                     best_pure;

  assign color.red   = red_i;
  assign color.green = green_i;
  assign color.blue  = blue_i;

  assign in_ready_o  = dist_ready;
  assign accept      = in_valid_i && dist_ready;
  assign wr_en       = accept && (op_e'(operation_i) == OpWrite);
  assign query_valid = in_valid_i && (op_e'(operation_i) == OpQuery);

  assign cfg_ready_o = 1'b1;
  assign cfg_en      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pure_mode_q   <= 1'b0;
      pure_count_q  <= '0;
      block_count_q <= '0;
    end else if (cfg_en) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegPureMode:   pure_mode_q   <= cfg_data_i[0];
        RegPureCount:  pure_count_q  <= cfg_data_i;
        RegBlockCount: block_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (table_e'(table_select_i) == TblPure) begin
        pure_table_q[entry_index_i] <= color;
      end else begin
        block_table_q[entry_index_i] <= color;
      end
    end
  end

  assign sel_pure  = (pure_request_i || pure_mode_q) && (pure_count_q != '0);
  assign sel_count = sel_pure ? pure_count_q : block_count_q;

  for (genvar i = 0; i < PaletteDepth; i++) begin : g_sel
    assign sel_entries[i] = sel_pure ? pure_table_q[i] : block_table_q[i];
    assign lane_mask[i]   = CntW'(i) < sel_count;
  end

  npcm_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (query_valid),
    .in_ready_o (dist_ready),
    .color_i    (color),
    .entries_i  (sel_entries),
    .mask_i     (lane_mask),
    .sel_pure_i (sel_pure),
    .out_valid_o(dist_valid),
    .out_ready_i(tree_ready),
    .nodes_o    (dist_nodes),
    .sel_pure_o (dist_pure)
  );

  npcm_min_tree u_min_tree (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dist_valid),
    .in_ready_o (tree_ready),
    .nodes_i    (dist_nodes),
    .sel_pure_i (dist_pure),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .best_o     (best),
    .sel_pure_o (best_pure)
  );

  assign found_o           = best.vld;
  assign used_pure_table_o = best_pure;
  assign best_index_o      = best.idx;
  assign best_distance_o   = best.distance;

endmodule

// ===== hw/rtl/npcm_checker.sv =====
module npcm_checker import npcm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               found_o,
  input logic               used_pure_table_o,
  input logic [IdxW-1:0]    best_index_o,
  input logic [DistW-1:0]   best_distance_o
);

  // A draining output never blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while the output is ready");

  // An empty search reports neither a table nor a position, and a zero distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |->
      (!used_pure_table_o && (best_index_o == '0) && (best_distance_o == '0)))
    else $error("empty result carries nonzero fields");

  // No squared RGB distance exceeds three full-scale squares.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_distance_o <= DistW'(195075)))
    else $error("distance out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(found_o) && $stable(used_pure_table_o) &&
       $stable(best_index_o) && $stable(best_distance_o)))
    else $error("stalled result changed");

endmodule

bind nearest_palette_color_match npcm_checker u_npcm_checker (.*);
